// ===== src/tiled_4bpp_icon_to_rgba_decoder_macros.svh =====
// Assertion macros for the tiled 4bpp icon decoder checker.
`ifndef TILED_4BPP_ICON_TO_RGBA_DECODER_MACROS_SVH
`define TILED_4BPP_ICON_TO_RGBA_DECODER_MACROS_SVH

// same-cycle implication
`define ICD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ICD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/icd_pkg.sv =====
// Shared types, constants and the colour-widening function of the tiled 4bpp icon decoder.
`timescale 1ns / 1ps
package icd_pkg;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PW    = 2;
  localparam int OUT_CW    = 3;

  localparam logic MODE_PAL_WRITE = 1'b0;
  localparam logic MODE_GLYPH     = 1'b1;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic       clear;
    logic       last;
  } pix_meta_t;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } out_pix_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

endpackage

// ===== src/tiled_4bpp_icon_to_rgba_decoder.sv =====
// Top level of the tiled 4bpp icon decoder.
//
// Input channel (in_*): one request per accepted edge. Mode 0 writes a BGR555
// colour into slot in_palette_slot of the chosen palette; mode 1 decodes one
// glyph byte into two RGBA8 atlas pixels, low nibble first.
// Result channel (out_*): one pixel per accepted edge, last_of_pair marks
// the high-nibble pixel.
// Input pacing: a glyph byte needs one palette-memory read per pixel (one
// read port); a palette write or an out-of-range icon needs no read.
// A pixel passes the request register, the read data register and the queue.
// A 4-entry output queue sits before the result channel; reads are only
// issued when the queue has room, so while the receiver stalls the block
// keeps accepting until the queue fills, then raises in_stall.
// Reset (rst_n low, synchronous) empties the queue and the request register;
// palette contents are not cleared and must be written before being used.
`timescale 1ns / 1ps
module tiled_4bpp_icon_to_rgba_decoder #(
  parameter int ICON_COUNT    = 1024,
  parameter int ATLAS_WIDTH   = 1024,
  parameter int PALETTE_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [9:0]  in_icon_number,
  input  logic [8:0]  in_byte_offset,
  input  logic [7:0]  in_pixel_pair,
  input  logic [7:0]  in_palette_choice,
  input  logic [3:0]  in_palette_slot,
  input  logic [15:0] in_colour_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_pixel_x,
  output logic [9:0]  out_pixel_y,
  output logic [7:0]  out_alpha,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic        out_last_of_pair
);

  localparam int PAL_DEPTH = PALETTE_COUNT * 16;
  localparam int AW        = $clog2(PAL_DEPTH);

  logic                          room, mem_we, rd_valid, pop;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [14:0]                   mem_wdata, rdata;
  logic [icd_pkg::OUT_CW-1:0]    cnt;
  icd_pkg::pix_meta_t            rd_meta;
  icd_pkg::out_pix_t             push_data, head;

  assign room = (32'(cnt) + 32'(rd_valid)) < 32'(icd_pkg::OUT_DEPTH);

  icd_issue #(
    .ICON_COUNT   (ICON_COUNT),
    .ATLAS_WIDTH  (ATLAS_WIDTH),
    .PALETTE_COUNT(PALETTE_COUNT),
    .AW           (AW)
  ) u_issue (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_icon_number   (in_icon_number),
    .in_byte_offset   (in_byte_offset),
    .in_pixel_pair    (in_pixel_pair),
    .in_palette_choice(in_palette_choice),
    .in_palette_slot  (in_palette_slot),
    .in_colour_word   (in_colour_word),
    .room             (room),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr        (mem_raddr),
    .rd_valid_r       (rd_valid),
    .rd_meta_r        (rd_meta)
  );

  icd_pal_mem #(
    .DEPTH(PAL_DEPTH),
    .AW   (AW)
  ) u_pal_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr  (mem_raddr),
    .rdata_r(rdata)
  );

  always_comb begin
    push_data.x    = rd_meta.x;
    push_data.y    = rd_meta.y;
    push_data.last = rd_meta.last;
    if (rd_meta.clear) begin
      push_data.alpha = 8'd0;
      push_data.blue  = 8'd0;
      push_data.green = 8'd0;
      push_data.red   = 8'd0;
    end else begin
      push_data.alpha = 8'hFF;
      push_data.blue  = icd_pkg::widen5(rdata[14:10]);
      push_data.green = icd_pkg::widen5(rdata[9:5]);
      push_data.red   = icd_pkg::widen5(rdata[4:0]);
    end
  end

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && !out_stall;

  icd_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rd_valid),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .cnt_r    (cnt)
  );

  assign out_pixel_x      = head.x;
  assign out_pixel_y      = head.y;
  assign out_alpha        = head.alpha;
  assign out_blue         = head.blue;
  assign out_green        = head.green;
  assign out_red          = head.red;
  assign out_last_of_pair = head.last;

endmodule

// ===== src/icd_pal_mem.sv =====
// Palette store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module icd_pal_mem #(
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [14:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [14:0]   rdata_r
);

  logic [14:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

// ===== src/icd_issue.sv =====
// Request register and sequencer: palette writes and per-pixel palette reads.
`timescale 1ns / 1ps
module icd_issue #(
  parameter int ICON_COUNT    = 1024,
  parameter int ATLAS_WIDTH   = 1024,
  parameter int PALETTE_COUNT = 3,
  parameter int AW            = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [9:0]          in_icon_number,
  input  logic [8:0]          in_byte_offset,
  input  logic [7:0]          in_pixel_pair,
  input  logic [7:0]          in_palette_choice,
  input  logic [3:0]          in_palette_slot,
  input  logic [15:0]         in_colour_word,
  input  logic                room,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [14:0]         mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  output logic                rd_valid_r,
  output icd_pkg::pix_meta_t  rd_meta_r
);

  localparam int COLS  = (ATLAS_WIDTH / 32 < 1) ? 1 : ATLAS_WIDTH / 32;
  localparam int RECIP = ((1 << 20) + COLS - 1) / COLS;

  logic        busy_r, busy_nxt;
  logic        phase_r, phase_nxt;
  logic        mode_r, skip_r;
  logic [9:0]  icon_r, row_r;
  logic [8:0]  off_r;
  logic [7:0]  pair_r;
  logic [3:0]  pal4_r, slot_r;
  logic [14:0] colour_r;

  logic        accept, done, issue;
  logic [31:0] row_prod;
  logic [3:0]  in_pal4, nib;
  logic [4:0]  col5;
  icd_pkg::pix_meta_t meta;

  assign row_prod = 32'(in_icon_number) * 32'(RECIP);
  assign in_pal4  = (32'(in_palette_choice) < 32'(PALETTE_COUNT)) ? in_palette_choice[3:0]
                                                                    : 4'd0;

  always_comb begin
    issue  = 1'b0;
    done   = 1'b0;
    mem_we = 1'b0;
    if (busy_r) begin
      priority if (mode_r == icd_pkg::MODE_PAL_WRITE) begin
        mem_we = 1'b1;
        done   = 1'b1;
      end else if (skip_r) begin
        done = 1'b1;
      end else if (room) begin
        issue = 1'b1;
        done  = phase_r;
      end else begin
        issue = 1'b0;
      end
    end
  end

  assign in_stall = busy_r && !done;
  assign accept   = in_valid && !in_stall;

  assign nib        = phase_r ? pair_r[7:4] : pair_r[3:0];
  assign col5       = icon_r[4:0] - 5'(32'(row_r) * 32'(COLS));
  assign mem_waddr  = AW'({pal4_r, slot_r});
  assign mem_wdata  = colour_r;
  assign mem_raddr  = AW'({pal4_r, nib});

  always_comb begin
    meta.x     = {col5, off_r[6:5], off_r[1:0], phase_r};
    meta.y     = {row_r[4:0], off_r[8:7], off_r[4:2]};
    meta.clear = (nib == 4'd0);
    meta.last  = phase_r;
  end

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    priority if (accept) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      phase_nxt = 1'b1;
    end else begin
      busy_nxt = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      phase_r    <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      phase_r    <= phase_nxt;
      rd_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_mode;
      skip_r   <= {1'b0, in_icon_number} >= 11'(ICON_COUNT);
      icon_r   <= in_icon_number;
      row_r    <= row_prod[29:20];
      off_r    <= in_byte_offset;
      pair_r   <= in_pixel_pair;
      pal4_r   <= in_pal4;
      slot_r   <= in_palette_slot;
      colour_r <= in_colour_word[14:0];
    end
    if (issue) begin
      rd_meta_r <= meta;
    end
  end

endmodule

// ===== src/icd_out_fifo.sv =====
// Output queue of finished pixels ahead of the result channel.
`timescale 1ns / 1ps
module icd_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  icd_pkg::out_pix_t             push_data,
  input  logic                          pop,
  output icd_pkg::out_pix_t             head,
  output logic [icd_pkg::OUT_CW-1:0]    cnt_r
);

  icd_pkg::out_pix_t             buf_r [icd_pkg::OUT_DEPTH];
  logic [icd_pkg::OUT_PW-1:0]    wptr_r, rptr_r;
  logic [icd_pkg::OUT_CW-1:0]    cnt_nxt;

  assign head = buf_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== src/icd_checker.sv =====
// Port-level checker for the tiled 4bpp icon decoder, bound to the top level.
`timescale 1ns / 1ps
`include "tiled_4bpp_icon_to_rgba_decoder_macros.svh"
module icd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_pixel_x,
  input logic [9:0]  out_pixel_y,
  input logic [7:0]  out_alpha,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_green,
  input logic [7:0]  out_red,
  input logic        out_last_of_pair
);

  logic [52:0] out_word;
  logic [23:0] out_rgb;

  assign out_word = {out_pixel_x, out_pixel_y, out_alpha, out_blue, out_green, out_red,
                     out_last_of_pair};
  assign out_rgb  = {out_blue, out_green, out_red};

  `ICD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")
  `ICD_ASSERT_NOW(a_alpha_code, out_valid, out_alpha == 8'd0 || out_alpha == 8'hFF, "alpha not 0 or 255")
  `ICD_ASSERT_NOW(a_clear_zero, out_valid && out_alpha == 8'd0, out_rgb == '0, "clear pixel has color")
  `ICD_ASSERT_NOW(a_pair_col, out_valid, out_pixel_x[0] == out_last_of_pair, "column parity off")

endmodule

bind tiled_4bpp_icon_to_rgba_decoder icd_checker u_icd_checker (.*);
